// File: sv/prlt_pkg.sv
// Package for the per-ID rate limit table: shared types and status codes.
// Used by the controller, the datapath and the top level; depends on nothing.
package prlt_pkg;

   localparam int HashBits   = 5;
   localparam int MaxEntries = 64;
   localparam int SlackNum   = 6;
   localparam int SlackDen   = 5;

   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_CREATED    = 3'd1,
      ST_ABSENT     = 3'd2,
      ST_FULL_GEN   = 3'd3,
      ST_SET        = 3'd4,
      ST_SET_REFUSE = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HEAD,
      S_HEAD_WAIT,
      S_READ,
      S_READ_WAIT,
      S_CHECK,
      S_DECIDE,
      S_INSERT,
      S_THROTTLE,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // latch the input word
      logic head_rd;    // read bucket head
      logic take_head;  // cursor from head read data
      logic ent_rd;     // read entry at cursor
      logic step;       // tail <= cursor, cursor <= next
      logic do_insert;  // write a new entry and link it
      logic set_iv;     // update interval of found entry
      logic do_thr;     // apply throttle to found/new entry
      logic set_res;    // register result
      logic publish;    // move the registered result to the output word
      status_type st;   // status for the result
      logic force_ntf;  // notify 1 for the generic entry
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mode;
      logic create;
      logic cur_ok;     // cursor is a valid link within the filled part
      logic match;      // entry at cursor holds the identifier
      logic full;       // table holds MaxEntries entries
      logic steps_done; // walk bound reached
   } stat_type;

endpackage

// File: sv/prlt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module prlt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: sv/prlt_datapath.sv
// Datapath: bucket heads, entry memories, chain cursor, throttle arithmetic.
// Depends on prlt_pkg and prlt_ram.
module prlt_datapath #(
   parameter int HashBits   = prlt_pkg::HashBits,
   parameter int MaxEntries = prlt_pkg::MaxEntries
) (
   input  logic               clock,
   input  logic               reset,
   input  prlt_pkg::cmd_type  cmd,
   output prlt_pkg::stat_type stat,
   input  logic [81:0]        in_word,
   input  logic [15:0]        default_interval,
   output logic               res_notify_ff,
   output logic [2:0]         res_status_ff
);
   localparam int Buckets = 1 << HashBits;
   localparam int PtrW    = $clog2(MaxEntries + 1);
   localparam int IdxW    = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int DepthE  = (MaxEntries > 1) ? MaxEntries : 2;
   localparam int DepthB  = (Buckets > 1) ? Buckets : 2;
   localparam int BktW    = (HashBits > 0) ? HashBits : 1;
   localparam logic [PtrW-1:0] Nil = PtrW'(MaxEntries);

   logic            mode_ff;
   logic [31:0]     id_ff;
   logic [31:0]     now_ff;
   logic            create_ff;
   logic [15:0]     iv_in_ff;
   logic [BktW-1:0] bucket_ff;
   logic [PtrW-1:0] cur_ff, cur_in;
   logic [PtrW-1:0] tail_ff, tail_in;
   logic [PtrW-1:0] count_ff;
   logic [PtrW-1:0] steps_ff;
   logic [Buckets-1:0] hvalid_ff;
   logic            res_notify_in;
   logic            stage_notify_ff;
   logic [2:0]      stage_status_ff;

   logic [PtrW-1:0] head_rdata;
   logic [31:0]     id_rdata;
   logic [15:0]     iv_rdata;
   logic [31:0]     last_rdata;
   logic [PtrW-1:0] next_rdata;

   logic            head_we;
   logic [PtrW-1:0] head_wdata;
   logic            id_we, iv_we, last_we, next_we;
   logic [IdxW-1:0] ent_waddr, next_waddr;
   logic [15:0]     iv_wdata;
   logic [31:0]     last_wdata;
   logic [PtrW-1:0] next_wdata;
   logic [BktW-1:0] hash;

   assign hash = id_ff[BktW-1:0] ^ id_ff[2*BktW-1:BktW];

   // Entry fields used by the throttle: a fresh entry reads as created.
   // The gap is beyond 1.2 intervals exactly when 5 * gap > 6 * interval.
   logic            fresh_ff;
   logic [15:0]     iv_use;
   logic [31:0]     last_use;
   logic [31:0]     delta;
   logic [34:0]     slack;
   logic [34:0]     delta_x5;
   logic            fire;
   logic [IdxW-1:0] cur_idx;

   assign cur_idx  = cur_ff[IdxW-1:0];
   assign iv_use   = fresh_ff ? default_interval : iv_rdata;
   assign last_use = fresh_ff ? 32'd0 : last_rdata;
   assign delta    = now_ff - last_use;
   assign slack    = (35'(iv_use) << 2) + (35'(iv_use) << 1);
   assign delta_x5 = (35'(delta) << 2) + 35'(delta);
   assign fire     = (iv_use == 16'd0) || (delta > 32'(iv_use));

   always_comb begin
      head_we    = cmd.do_insert && (tail_ff == Nil);
      head_wdata = count_ff;
      id_we      = cmd.do_insert;
      iv_we      = cmd.do_insert || cmd.set_iv;
      iv_wdata   = (cmd.do_insert && mode_ff) ? iv_in_ff :
                   (cmd.do_insert ? default_interval : iv_in_ff);
      ent_waddr  = cmd.do_insert ? count_ff[IdxW-1:0] : cur_idx;
      last_we    = cmd.do_insert || (cmd.do_thr && fire);
      if (cmd.do_insert) begin
         last_wdata = 32'd0;
      end else if (delta == 32'd0 || delta_x5 > slack) begin
         last_wdata = now_ff;
      end else begin
         last_wdata = last_use + 32'(iv_use);
      end
      // Both the new entry's next and the tail's link are written; the tail
      // link goes in the next cycle through the same port.
      next_we    = cmd.do_insert;
      next_waddr = count_ff[IdxW-1:0];
      next_wdata = Nil;
   end

   // Pending tail link write after an insert.
   logic            link_ff;
   logic [IdxW-1:0] link_addr_ff;
   logic [PtrW-1:0] link_data_ff;

   prlt_ram #(.Width(PtrW), .Depth(DepthB)) u_head (
      .clock, .we(head_we), .waddr(bucket_ff), .wdata(head_wdata),
      .raddr(hash), .rdata(head_rdata));
   prlt_ram #(.Width(32), .Depth(DepthE)) u_ident (
      .clock, .we(id_we), .waddr(ent_waddr), .wdata(id_ff),
      .raddr(cur_idx), .rdata(id_rdata));
   prlt_ram #(.Width(16), .Depth(DepthE)) u_interval (
      .clock, .we(iv_we), .waddr(ent_waddr), .wdata(iv_wdata),
      .raddr(cur_idx), .rdata(iv_rdata));
   prlt_ram #(.Width(32), .Depth(DepthE)) u_last (
      .clock, .we(last_we), .waddr(ent_waddr), .wdata(last_wdata),
      .raddr(cur_idx), .rdata(last_rdata));
   prlt_ram #(.Width(PtrW), .Depth(DepthE)) u_next (
      .clock, .we(next_we || link_ff), .waddr(link_ff ? link_addr_ff : next_waddr),
      .wdata(link_ff ? link_data_ff : next_wdata), .raddr(cur_idx), .rdata(next_rdata));

   always_comb begin
      cur_in  = cur_ff;
      tail_in = tail_ff;
      if (cmd.take_head) begin
         cur_in  = hvalid_ff[bucket_ff] ? head_rdata : Nil;
         tail_in = Nil;
      end else if (cmd.step) begin
         tail_in = cur_ff;
         cur_in  = next_rdata;
      end else if (cmd.do_insert) begin
         // The cursor moves to the new entry so that its throttle lands there.
         cur_in  = count_ff;
      end
      res_notify_in = cmd.force_ntf || (cmd.do_thr && fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         hvalid_ff       <= '0;
         link_ff         <= 1'b0;
         res_notify_ff   <= 1'b0;
         res_status_ff   <= 3'd0;
         stage_notify_ff <= 1'b0;
         stage_status_ff <= 3'd0;
         fresh_ff        <= 1'b0;
      end else begin
         link_ff <= cmd.do_insert && (tail_ff != Nil);
         if (cmd.do_insert) begin
            count_ff <= count_ff + PtrW'(1);
            fresh_ff <= 1'b1;
            if (tail_ff == Nil) begin
               hvalid_ff[bucket_ff] <= 1'b1;
            end
         end else if (cmd.load) begin
            fresh_ff <= 1'b0;
         end
         if (cmd.set_res) begin
            stage_notify_ff <= res_notify_in;
            stage_status_ff <= cmd.st;
         end
         if (cmd.publish) begin
            res_notify_ff <= stage_notify_ff;
            res_status_ff <= stage_status_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= in_word[0];
         id_ff     <= in_word[32:1];
         now_ff    <= in_word[64:33];
         create_ff <= in_word[65];
         iv_in_ff  <= in_word[81:66];
      end
      if (cmd.head_rd) begin
         bucket_ff <= hash;
      end
      if (cmd.take_head) begin
         steps_ff <= '0;
      end else if (cmd.step) begin
         steps_ff <= steps_ff + PtrW'(1);
      end
      cur_ff       <= cur_in;
      tail_ff      <= tail_in;
      link_addr_ff <= tail_ff[IdxW-1:0];
      link_data_ff <= count_ff;
   end

   assign stat.mode       = mode_ff;
   assign stat.create     = create_ff;
   assign stat.cur_ok     = (cur_ff < count_ff) && (cur_ff < Nil);
   assign stat.match      = (id_rdata == id_ff);
   assign stat.full       = (count_ff == Nil);
   assign stat.steps_done = (steps_ff == Nil);

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= Nil) else $error("entry count beyond table size");
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |-> count_ff < Nil) else $error("insert into full table");
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> link_ff == ($past(tail_ff) != Nil))
      else $error("tail link write lost");
endmodule

// File: sv/prlt_ctrl.sv
// Controller: sequences lookup, chain walk, insert, throttle and result.
// Depends on prlt_pkg.
module prlt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  prlt_pkg::stat_type stat,
   output prlt_pkg::cmd_type  cmd
);
   prlt_pkg::state_type state_ff, state_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.st       = prlt_pkg::ST_FOUND;
      req_tready   = 1'b0;
      case (state_ff)
         prlt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = prlt_pkg::S_HEAD;
            end
         end
         prlt_pkg::S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = prlt_pkg::S_HEAD_WAIT;
         end
         prlt_pkg::S_HEAD_WAIT: begin
            cmd.take_head = 1'b1;
            found_in      = 1'b0;
            state_in      = prlt_pkg::S_READ;
         end
         prlt_pkg::S_READ: begin
            if (!stat.cur_ok || stat.steps_done) begin
               state_in = prlt_pkg::S_DECIDE;
            end else begin
               state_in = prlt_pkg::S_READ_WAIT;
            end
         end
         prlt_pkg::S_READ_WAIT: state_in = prlt_pkg::S_CHECK;
         prlt_pkg::S_CHECK: begin
            if (stat.match) begin
               found_in = 1'b1;
               state_in = prlt_pkg::S_DECIDE;
            end else begin
               cmd.step = 1'b1;
               state_in = prlt_pkg::S_READ;
            end
         end
         prlt_pkg::S_DECIDE: begin
            state_in = prlt_pkg::S_OUT;
            if (stat.mode) begin
               cmd.set_res = 1'b1;
               cmd.st      = prlt_pkg::ST_SET;
               if (found_ff) begin
                  cmd.set_iv = 1'b1;
               end else if (!stat.full) begin
                  cmd.do_insert = 1'b1;
               end else begin
                  cmd.st = prlt_pkg::ST_SET_REFUSE;
               end
            end else if (found_ff) begin
               cmd.do_thr  = 1'b1;
               cmd.set_res = 1'b1;
               cmd.st      = prlt_pkg::ST_FOUND;
            end else if (!stat.create) begin
               cmd.set_res = 1'b1;
               cmd.st      = prlt_pkg::ST_ABSENT;
            end else if (!stat.full) begin
               cmd.do_insert = 1'b1;
               state_in      = prlt_pkg::S_THROTTLE;
            end else begin
               cmd.set_res   = 1'b1;
               cmd.force_ntf = 1'b1;
               cmd.st        = prlt_pkg::ST_FULL_GEN;
            end
         end
         prlt_pkg::S_THROTTLE: begin
            cmd.do_thr  = 1'b1;
            cmd.set_res = 1'b1;
            cmd.st      = prlt_pkg::ST_CREATED;
            state_in    = prlt_pkg::S_OUT;
         end
         prlt_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = prlt_pkg::S_IDLE;
            end
         end
         default: state_in = prlt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prlt_pkg::S_IDLE;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |-> !found_ff) else $error("insert of a found identifier");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == prlt_pkg::S_HEAD)
      else $error("accepted word not processed");
endmodule

// File: sv/packet_id_rate_limit_table.sv
// Top level of the per-packet-ID notification rate limiter.
// Depends on prlt_pkg, prlt_ctrl and prlt_datapath (with prlt_ram).
//
// Usage: one request word per packet event or set operation enters on the
// req_ channel; exactly one result word (notify, status) leaves on rsp_.
// The identifier is hashed into a bucket whose chain of entries is walked
// one entry at a time, each step waiting on the registered read of the
// entry memories; at most MAX_ENTRIES entries are visited. After acceptance
// the controller passes S_HEAD, S_HEAD_WAIT, then S_READ, S_READ_WAIT and
// S_CHECK per entry, S_DECIDE, S_THROTTLE for a packet event that creates an
// entry, and S_OUT, which publishes the result; then it takes the next word
// in S_IDLE. One word is handled at a time. The result is held in an output
// register; a new request is accepted while it waits, and the block stalls
// only when a second result is ready before the first is taken. Reset
// empties the table at once: bucket heads carry valid bits, and the entry
// count returns to zero. The user must write the default interval register
// through csr_ only while the block is idle; the block does not enforce it.
module packet_id_rate_limit_table #(
   parameter int HASH_BITS   = prlt_pkg::HashBits,
   parameter int MAX_ENTRIES = prlt_pkg::MaxEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[0], packet_id[32:1], now_ms[64:33], create_if_missing[65],
   // interval_ms[81:66], zero fill[87:82]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // notify[0], status[3:1], zero fill[7:4]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   prlt_pkg::cmd_type  cmd;
   prlt_pkg::stat_type stat;
   logic [15:0]        default_interval_ff;
   logic               notify;
   logic [2:0]         status;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_interval_ff <= 16'd0;
      end else if (csr_we) begin
         default_interval_ff <= csr_wdata;
      end
   end

   prlt_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd);

   prlt_datapath #(.HashBits(HASH_BITS), .MaxEntries(MAX_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .stat, .in_word(req_tdata[81:0]),
      .default_interval(default_interval_ff),
      .res_notify_ff(notify), .res_status_ff(status));

   assign rsp_tdata = {4'd0, status, notify};
endmodule
